FILE: sv/line_sensor_centroid_unit_macros.svh
// assertion macros used by the line sensor centroid unit datapath
`ifndef LINE_SENSOR_CENTROID_UNIT_MACROS_SVH
`define LINE_SENSOR_CENTROID_UNIT_MACROS_SVH

// clocked check, off while in reset
`define LSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked implication check
`define LSC_ASSERT_IMP(lbl, ante, cons, msg) \
	`LSC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: sv/lsc_pkg.sv
// shared constants, types and microcode table of the line sensor centroid unit
package lsc_pkg;

	localparam int SENSOR_COUNT = 8;

	localparam int SAMPLE_W = 8;
	localparam int CFG_W    = 8;
	localparam int POS_W    = 16;
	localparam int DARK_W   = 17;
	localparam int QUO_W    = 16;
	localparam int CNT_W    = 4;

	localparam int SLOT_W   = $clog2(SENSOR_COUNT);
	localparam int WT_W     = SLOT_W + 1;
	localparam int LEVEL_W  = $clog2(SENSOR_COUNT * 65536 + 1);
	localparam int WEIGHT_W = $clog2(65536 * SENSOR_COUNT * (SENSOR_COUNT + 1) / 2 + 1);
	localparam int DIV_W    = $clog2((SENSOR_COUNT - 1) * SENSOR_COUNT * 65536 + 1);
	localparam int REM_W    = DIV_W + 1;
	localparam int NUM_W    = DIV_W + 3;

	localparam logic [DARK_W-1:0] DARK_ONE  = DARK_W'(65536);
	localparam logic [POS_W-1:0]  POS_ONE   = POS_W'(16384);
	localparam logic [CNT_W-1:0]  STEP_LAST = CNT_W'(15);

	localparam logic [CFG_W-1:0] FLOOR_RESET   = CFG_W'(10);
	localparam logic [CFG_W-1:0] CEILING_RESET = CFG_W'(100);

	typedef enum logic {
		REG_FLOOR   = 1'b0,
		REG_CEILING = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_DLOAD,
		OP_DSTEP,
		OP_ACC,
		OP_PREP,
		OP_PLOAD,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_IDLE,
		C_CNT,
		C_NOTLAST,
		C_LOST,
		C_ALWAYS
	} cond_t;

	localparam int PC_W = 3;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_WAIT   = PC_W'(0);
	localparam pc_t PC_DLOAD  = PC_W'(1);
	localparam pc_t PC_DSTEP  = PC_W'(2);
	localparam pc_t PC_ACC    = PC_W'(3);
	localparam pc_t PC_PREP   = PC_W'(4);
	localparam pc_t PC_PLOAD  = PC_W'(5);
	localparam pc_t PC_PSTEP  = PC_W'(6);
	localparam pc_t PC_OUT    = PC_W'(7);

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic take;
	} ctrl_t;

	typedef struct packed {
		logic cnt_nz;
		logic last;
		logic lost;
	} status_t;

	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		case (pc)
			PC_WAIT:  w = '{op: OP_WAIT,  cond: C_IDLE,    target: PC_WAIT};
			PC_DLOAD: w = '{op: OP_DLOAD, cond: C_NONE,    target: PC_WAIT};
			PC_DSTEP: w = '{op: OP_DSTEP, cond: C_CNT,     target: PC_DSTEP};
			PC_ACC:   w = '{op: OP_ACC,   cond: C_NOTLAST, target: PC_WAIT};
			PC_PREP:  w = '{op: OP_PREP,  cond: C_NONE,    target: PC_WAIT};
			PC_PLOAD: w = '{op: OP_PLOAD, cond: C_LOST,    target: PC_OUT};
			PC_PSTEP: w = '{op: OP_DSTEP, cond: C_CNT,     target: PC_PSTEP};
			PC_OUT:   w = '{op: OP_OUT,   cond: C_ALWAYS,  target: PC_WAIT};
			default:  w = '{op: OP_WAIT,  cond: C_ALWAYS,  target: PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/line_sensor_centroid_unit.sv
// top level of the line sensor centroid unit: configuration registers, sequencer, datapath
//
// Takes one 8-bit sample per request, in sensor order, and after every eighth sample
// gives one result: the line position in signed Q2.14 (+1.0 at the first sensor, -1.0
// at the last) and line_lost when no sensor saw any darkness. A request is taken when
// start is high and busy is low; busy then stays high through the divider load, the
// divide steps and the accumulate step, as the shared 16-step restoring divider forms
// each normalized darkness one quotient bit per cycle. After the last sample of a scan
// the same divider forms the position in the prepare, load, divide (skipped when the
// line is lost) and output steps; done pulses for one cycle, and busy stays high until
// that cycle. The result on position and line_lost holds from done to the next and
// cannot be held off. The user must write dark_floor and dark_ceiling through write_en,
// reg_index and write_data while idle; the block itself does not enforce this.
module line_sensor_centroid_unit import lsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [SAMPLE_W-1:0]      sample,
	output logic signed [POS_W-1:0]  position,
	output logic                     line_lost,
	output logic                     done,
	input  logic                     write_en,
	input  logic                     reg_index,
	input  logic [CFG_W-1:0]         write_data
);

	logic [CFG_W-1:0] dark_floor_q;
	logic [CFG_W-1:0] dark_ceiling_q;
	ctrl_t            ctrl;
	status_t          stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_floor_q   <= FLOOR_RESET;
			dark_ceiling_q <= CEILING_RESET;
		end else if (write_en) begin
			case (reg_index_t'(reg_index))
				REG_FLOOR:   dark_floor_q   <= write_data;
				REG_CEILING: dark_ceiling_q <= write_data;
				default: begin
				end
			endcase
		end
	end

	lsc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	lsc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.sample       (sample),
		.dark_floor   (dark_floor_q),
		.dark_ceiling (dark_ceiling_q),
		.stat         (stat),
		.position     (position),
		.line_lost    (line_lost),
		.done         (done)
	);

endmodule

FILE: sv/lsc_seq.sv
// microcode sequencer: step counter, control word fetch and conditional jumps
module lsc_seq import lsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t stat,
	output ctrl_t   ctrl,
	output logic    busy
);

	pc_t    pc_q;
	uword_t uw;
	logic   jump;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.cond)
			C_NONE:    jump = 1'b0;
			C_IDLE:    jump = !start;
			C_CNT:     jump = stat.cnt_nz;
			C_NOTLAST: jump = !stat.last;
			C_LOST:    jump = stat.lost;
			C_ALWAYS:  jump = 1'b1;
			default:   jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= jump ? uw.target : pc_q + PC_W'(1);
		end
	end

	assign ctrl.op   = uw.op;
	assign ctrl.take = (uw.op == OP_WAIT) && start;
	assign busy      = (uw.op != OP_WAIT);

endmodule

FILE: sv/lsc_datapath.sv
// datapath: shared restoring divider, darkness accumulators and position result
module lsc_datapath import lsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	input  logic [SAMPLE_W-1:0]      sample,
	input  logic [CFG_W-1:0]         dark_floor,
	input  logic [CFG_W-1:0]         dark_ceiling,
	output status_t                  stat,
	output logic signed [POS_W-1:0]  position,
	output logic                     line_lost,
	output logic                     done
);

	`include "line_sensor_centroid_unit_macros.svh"

	logic [SAMPLE_W-1:0]     sample_q;
	logic [REM_W-1:0]        rem_q;
	logic [DIV_W-1:0]        div_q;
	logic [QUO_W-1:0]        quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [LEVEL_W-1:0]      level_q;
	logic [WEIGHT_W-1:0]     weight_q;
	logic [NUM_W-1:0]        num_q;
	logic [DIV_W-1:0]        den_q;
	logic                    neg_q;
	logic                    lost_q;
	logic [POS_W-1:0]        position_q;
	logic                    line_lost_q;
	logic                    done_q;

	logic                    span_bad;
	logic [CFG_W-1:0]        span;
	logic                    sat;
	logic [REM_W-1:0]        div_ext;
	logic                    rem_ge;
	logic [REM_W-1:0]        rem_sel;
	logic [DARK_W-1:0]       dark;
	logic [WT_W-1:0]         wt;
	logic [DARK_W+WT_W-1:0]  prod;
	logic                    last;
	logic [NUM_W-1:0]        mag;
	logic [QUO_W:0]          rnd;
	logic [POS_W-1:0]        mag_pos;
	logic [POS_W-1:0]        pos_val;
	logic                    pos_ok;

	// span of zero or below means full darkness on every sensor
	assign span_bad = (dark_ceiling <= dark_floor);
	assign span     = dark_ceiling - dark_floor;
	assign sat      = (sample_q >= span);

	// one restoring step: compare, subtract, shift
	assign div_ext = REM_W'(div_q);
	assign rem_ge  = (rem_q >= div_ext);
	assign rem_sel = rem_ge ? (rem_q - div_ext) : rem_q;

	always_comb begin
		if (span_bad) begin
			dark = DARK_ONE;
		end else if (sat) begin
			dark = '0;
		end else begin
			dark = DARK_ONE - DARK_W'(quo_q);
		end
	end

	assign wt   = WT_W'(slot_q) + WT_W'(1);
	assign prod = (DARK_W+WT_W)'(dark) * (DARK_W+WT_W)'(wt);
	assign last = (slot_q == SLOT_W'(SENSOR_COUNT - 1));

	assign mag = num_q[NUM_W-1] ? (~num_q + NUM_W'(1)) : num_q;

	// quotient holds twice the result, so the low bit rounds half away from zero
	assign rnd     = ({1'b0, quo_q} + (QUO_W+1)'(1)) >> 1;
	assign mag_pos = (rnd > (QUO_W+1)'(POS_ONE)) ? POS_ONE : POS_W'(rnd);
	assign pos_val = neg_q ? (~mag_pos + POS_W'(1)) : mag_pos;

	assign pos_ok = ($signed(position_q) <= $signed(POS_ONE))
		&& ($signed(position_q) >= -$signed(POS_ONE));

	assign stat.cnt_nz = (cnt_q != '0);
	assign stat.last   = last;
	assign stat.lost   = (level_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			level_q  <= '0;
			weight_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ctrl.op)
				OP_ACC: begin
					level_q  <= level_q + LEVEL_W'(dark);
					weight_q <= weight_q + WEIGHT_W'(prod);
					if (!last) begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				OP_OUT: begin
					level_q  <= '0;
					weight_q <= '0;
					slot_q   <= '0;
					done_q   <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_WAIT: begin
				if (ctrl.take) begin
					sample_q <= sample;
				end
			end
			OP_DLOAD: begin
				rem_q <= REM_W'({sample_q, 1'b0});
				div_q <= DIV_W'(span);
				quo_q <= '0;
				cnt_q <= STEP_LAST;
			end
			OP_DSTEP: begin
				rem_q <= {rem_sel[REM_W-2:0], 1'b0};
				quo_q <= {quo_q[QUO_W-2:0], rem_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_PREP: begin
				num_q <= NUM_W'(level_q) * NUM_W'(SENSOR_COUNT + 1)
					- (NUM_W'(weight_q) << 1);
				den_q <= DIV_W'(level_q) * DIV_W'(SENSOR_COUNT - 1);
			end
			OP_PLOAD: begin
				neg_q  <= num_q[NUM_W-1];
				lost_q <= (level_q == '0);
				rem_q  <= REM_W'(mag);
				div_q  <= den_q;
				quo_q  <= '0;
				cnt_q  <= STEP_LAST;
			end
			OP_OUT: begin
				position_q  <= lost_q ? '0 : pos_val;
				line_lost_q <= lost_q;
			end
			default: begin
			end
		endcase
	end

	assign position  = $signed(position_q);
	assign line_lost = line_lost_q;
	assign done      = done_q;

	`LSC_ASSERT_IMP(a_done_single, done_q, ##1 !done_q, "result strobe longer than one cycle")
	`LSC_ASSERT_IMP(a_lost_zero, done_q && line_lost_q, position_q == '0, "lost line, position set")
	`LSC_ASSERT_IMP(a_pos_range, done_q && !line_lost_q, pos_ok, "position out of range")
	`LSC_ASSERT(a_slot_range, slot_q <= SLOT_W'(SENSOR_COUNT - 1), "slot count past last sensor")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// testbench for the line sensor centroid unit: directed and random scans checked by a predictor
module tb import lsc_pkg::*; ();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int SAMPLE_ITEMS = 1200;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic                    line_lost;
	} scan_result_t;

	typedef enum int {
		PAT_RANDOM,
		PAT_IN_SPAN,
		PAT_LINE,
		PAT_BRIGHT,
		PAT_EXTREME
	} scan_pattern_t;

	class centroid_scoreboard;
		logic [CFG_W-1:0] floor_lvl;
		logic [CFG_W-1:0] ceiling_lvl;
		int unsigned      slot;
		longint unsigned  weight_sum;
		longint unsigned  level_sum;
		scan_result_t     expected_q[$];
		int               errors;

		function new();
			floor_lvl   = FLOOR_RESET;
			ceiling_lvl = CEILING_RESET;
			slot        = 0;
			weight_sum  = 0;
			level_sum   = 0;
			errors      = 0;
		endfunction

		function void set_level(reg_index_t idx, logic [CFG_W-1:0] value);
			if (idx == REG_FLOOR) begin
				floor_lvl = value;
			end else begin
				ceiling_lvl = value;
			end
		endfunction

		// normalized darkness in Q1.16, one minus the raw sample over the calibration span
		function longint unsigned darkness(logic [SAMPLE_W-1:0] s);
			longint unsigned span;
			longint unsigned q;
			if (ceiling_lvl <= floor_lvl) begin
				return 65536;
			end
			span = ceiling_lvl - floor_lvl;
			q = s;
			q = (q << 16) / span;
			if (q >= 65536) begin
				return 0;
			end
			return 65536 - q;
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] s);
			longint unsigned d;
			longint          num;
			longint          den;
			longint          mag;
			longint          q;
			longint          r;
			scan_result_t    res;
			d = darkness(s);
			slot++;
			level_sum  += d;
			weight_sum += d * slot;
			if (slot < SENSOR_COUNT) begin
				return;
			end
			if (level_sum == 0) begin
				res.position  = '0;
				res.line_lost = 1'b1;
			end else begin
				num = (SENSOR_COUNT + 1) * longint'(level_sum) - 2 * longint'(weight_sum);
				den = (SENSOR_COUNT - 1) * longint'(level_sum);
				mag = (num < 0) ? -num : num;
				mag = mag * 16384;
				q = mag / den;
				r = mag % den;
				// round to nearest, ties away from zero
				if (2 * r >= den) begin
					q++;
				end
				if (q > 16384) begin
					q = 16384;
				end
				res.position  = POS_W'((num < 0) ? -q : q);
				res.line_lost = 1'b0;
			end
			expected_q.push_back(res);
			slot       = 0;
			weight_sum = 0;
			level_sum  = 0;
		endfunction

		function void check_result(logic signed [POS_W-1:0] pos, logic lost);
			scan_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result position=%0d line_lost=%0b", $time, pos, lost);
				return;
			end
			want = expected_q.pop_front();
			if (pos !== want.position) begin
				errors++;
				$display("%0t: position expected %0d actual %0d", $time, want.position, pos);
			end
			if (lost !== want.line_lost) begin
				errors++;
				$display("%0t: line_lost expected %0b actual %0b", $time, want.line_lost, lost);
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [SAMPLE_W-1:0]     sample;
	logic signed [POS_W-1:0] position;
	logic                    line_lost;
	logic                    done;
	logic                    write_en;
	logic                    reg_index;
	logic [CFG_W-1:0]        write_data;

	centroid_scoreboard sb;
	int unsigned        cycle_count;
	int unsigned        sent;

	line_sensor_centroid_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample     (sample),
		.position   (position),
		.line_lost  (line_lost),
		.done       (done),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(position, line_lost);
		end
	end

	task automatic send_sample(logic [SAMPLE_W-1:0] s, int unsigned gap, bit after_idle);
		if (gap > 0 || after_idle) begin
			@(negedge clk);
			start <= 1'b0;
			if (after_idle) begin
				do @(posedge clk); while (busy);
			end
			if (gap > 1) begin
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		start  <= 1'b1;
		sample <= s;
		do @(posedge clk); while (busy);
		sb.note_sample(s);
		sent++;
	endtask

	// drain all results and let the sequencer go quiet
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_W-1:0] fl, logic [CFG_W-1:0] cl);
		settle();
		@(negedge clk);
		write_en   <= 1'b1;
		reg_index  <= REG_FLOOR;
		write_data <= fl;
		sb.set_level(REG_FLOOR, fl);
		@(negedge clk);
		reg_index  <= REG_CEILING;
		write_data <= cl;
		sb.set_level(REG_CEILING, cl);
		@(negedge clk);
		write_en <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(scan_pattern_t pat, bit in_line);
		int unsigned span;
		span = (sb.ceiling_lvl > sb.floor_lvl) ? sb.ceiling_lvl - sb.floor_lvl : 0;
		case (pat)
			PAT_IN_SPAN: begin
				return (span > 0) ? SAMPLE_W'($urandom_range(span, 0))
					: SAMPLE_W'($urandom_range(255, 0));
			end
			PAT_LINE: begin
				if (in_line) begin
					return SAMPLE_W'($urandom_range(span / 3, 0));
				end
				return SAMPLE_W'($urandom_range(255, span));
			end
			PAT_BRIGHT:  return SAMPLE_W'($urandom_range(255, span));
			PAT_EXTREME: return $urandom_range(1, 0) ? 8'd255 : 8'd0;
			default:     return SAMPLE_W'($urandom_range(255, 0));
		endcase
	endfunction

	initial begin
		scan_pattern_t pat;
		int unsigned   pick;
		int unsigned   phase_len;
		int unsigned   line_lo;
		int unsigned   line_hi;
		int unsigned   pos_in_scan;
		bit            quiet;
		logic [CFG_W-1:0] fl;
		logic [CFG_W-1:0] cl;

		sb          = new();
		sent        = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		sample      <= '0;
		write_en    <= 1'b0;
		reg_index   <= REG_FLOOR;
		write_data  <= '0;
		pat         = PAT_RANDOM;
		line_lo     = 0;
		line_hi     = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// line under the first sensor, then the last, then no line at all
		for (int i = 0; i < SENSOR_COUNT; i++) send_sample((i == 0) ? 8'd0 : 8'd255, 0, 1'b0);
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			send_sample((i == SENSOR_COUNT - 1) ? 8'd0 : 8'd255, 0, 1'b0);
		end
		for (int i = 0; i < SENSOR_COUNT; i++) send_sample(8'd255, 0, 1'b0);
		// ceiling below floor: every sensor reads fully dark
		configure(8'd255, 8'd0);
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			send_sample(SAMPLE_W'($urandom_range(255, 0)), 0, 1'b0);
		end

		while (sent < SAMPLE_ITEMS) begin
			pick = $urandom_range(11, 0);
			case (pick)
				0:       begin fl = 8'd10;  cl = 8'd100; end
				1:       begin fl = 8'd0;   cl = 8'd255; end
				2:       begin fl = 8'd255; cl = 8'd0;   end
				3:       begin fl = 8'd0;   cl = 8'd1;   end
				4:       begin fl = 8'd128; cl = 8'd128; end
				5:       begin fl = 8'd0;   cl = 8'd0;   end
				6:       begin fl = 8'd255; cl = 8'd255; end
				7:       begin fl = 8'd254; cl = 8'd255; end
				default: begin
					fl = CFG_W'($urandom_range(255, 0));
					cl = CFG_W'($urandom_range(255, 0));
				end
			endcase
			configure(fl, cl);
			phase_len = $urandom_range(96, 8);
			quiet     = ($urandom_range(2, 0) == 0);
			for (int k = 0; k < phase_len; k++) begin
				pos_in_scan = sb.slot;
				if (pos_in_scan == 0 || k == 0) begin
					pick = $urandom_range(19, 0);
					if (pick < 8) begin
						pat = PAT_LINE;
					end else if (pick < 13) begin
						pat = PAT_IN_SPAN;
					end else if (pick < 16) begin
						pat = PAT_RANDOM;
					end else if (pick < 18) begin
						pat = PAT_BRIGHT;
					end else begin
						pat = PAT_EXTREME;
					end
					line_lo = $urandom_range(SENSOR_COUNT - 1, 0);
					line_hi = line_lo + $urandom_range(2, 0);
				end
				send_sample(pick_sample(pat, pos_in_scan >= line_lo && pos_in_scan <= line_hi),
					quiet ? 0 : $urandom_range(9, 0),
					!quiet && ($urandom_range(3, 0) == 0));
			end
		end

		settle();
		sb.errors += sb.expected_q.size();
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
